/* rtl/core/script_token_lexer_unit_defines.svh */
// assertion macros shared by the lexer checker
`ifndef SCRIPT_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define STL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// condition implies consequence in the next cycle
`define STL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

/* rtl/core/stl_pkg.sv */
`default_nettype none
package stl_pkg;

    // token kinds
    localparam logic [2:0] K_IDENT  = 3'd0;
    localparam logic [2:0] K_NUMBER = 3'd1;
    localparam logic [2:0] K_STRING = 3'd2;
    localparam logic [2:0] K_OP     = 3'd3;
    localparam logic [2:0] K_DBL_OP = 3'd4;
    localparam logic [2:0] K_CTRL   = 3'd5;
    localparam logic [2:0] K_UNCL   = 3'd6;

    // special characters
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_DOT    = 8'h2E;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // lexer modes
    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_IDENT  = 7'b0000010,
        M_NUMBER = 7'b0000100,
        M_STRING = 7'b0001000,
        M_OP     = 7'b0010000,
        M_DBL    = 7'b0100000,
        M_PREFIX = 7'b1000000
    } t_mode;

    // results of one item: optional end, optional char, optional end, in that order
    typedef struct packed {
        logic       end1_en;
        logic [2:0] end1_kind;
        logic       char_en;
        logic [7:0] char_val;
        logic       end2_en;
        logic [2:0] end2_kind;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qword;

    function automatic logic f_is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_dbl(input logic [7:0] c);
        return c == 8'h7C || c == 8'h26 || c == 8'h2B || c == 8'h2D;
    endfunction

    function automatic logic f_is_eq(input logic [7:0] c);
        return f_is_dbl(c) || c == 8'h3C || c == 8'h3E || c == 8'h21 || c == C_EQ
            || c == 8'h2A || c == 8'h2F;
    endfunction

    function automatic logic f_is_ctrl(input logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B
            || c == 8'h7D || c == 8'h3B || c == 8'h2C || c == C_DOT;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/stl_front.sv */
`default_nettype none
module stl_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_in_char,
    input  wire logic           i_end_of_text,
    input  wire logic           i_q_full,
    output stl_pkg::t_qword     o_push
);
    import stl_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_open, n_open;
    logic       r_esc, n_esc;
    t_entry     ent;
    logic       do_start;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // next state and results of one transaction
    always_comb begin
        n_mode   = r_mode;
        n_open   = r_open;
        n_esc    = r_esc;
        ent      = '0;
        ent.char_val = i_in_char;
        do_start = 1'b0;
        if (i_end_of_text) begin
            ent.end1_en = 1'b1;
            case (r_mode)
                M_IDENT:  ent.end1_kind = K_IDENT;
                M_NUMBER: ent.end1_kind = K_NUMBER;
                M_STRING: ent.end1_kind = K_STRING;
                M_OP:     ent.end1_kind = K_OP;
                M_DBL:    ent.end1_kind = K_DBL_OP;
                M_PREFIX: ent.end1_kind = K_UNCL;
                default:  ent.end1_en   = 1'b0;
            endcase
            n_mode = M_IDLE;
            n_open = '0;
            n_esc  = 1'b0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (f_is_alpha(i_in_char) || f_is_digit(i_in_char)
                        || i_in_char == C_UNDER) begin
                        ent.char_en = 1'b1;
                    end else begin
                        ent.end1_en   = 1'b1;
                        ent.end1_kind = K_IDENT;
                        n_mode        = M_IDLE;
                        do_start      = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (f_is_digit(i_in_char) || i_in_char == C_DOT) begin
                        ent.char_en = 1'b1;
                    end else begin
                        ent.end1_en   = 1'b1;
                        ent.end1_kind = K_NUMBER;
                        n_mode        = M_IDLE;
                        do_start      = 1'b1;
                    end
                end
                M_STRING: begin
                    if (r_esc) begin
                        ent.char_en = 1'b1;
                        n_esc       = 1'b0;
                    end else if (i_in_char == C_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (i_in_char == r_open) begin
                        ent.end1_en   = 1'b1;
                        ent.end1_kind = K_STRING;
                        n_mode        = M_IDLE;
                    end else begin
                        ent.char_en = 1'b1;
                    end
                end
                M_OP: begin
                    n_mode = M_IDLE;
                    if (i_in_char == C_EQ) begin
                        ent.char_en   = 1'b1;
                        ent.end2_en   = 1'b1;
                        ent.end2_kind = K_OP;
                    end else begin
                        ent.end1_en   = 1'b1;
                        ent.end1_kind = K_OP;
                        do_start      = 1'b1;
                    end
                end
                M_DBL: begin
                    n_mode = M_IDLE;
                    if (i_in_char == r_open) begin
                        ent.char_en   = 1'b1;
                        ent.end2_en   = 1'b1;
                        ent.end2_kind = K_DBL_OP;
                    end else begin
                        ent.end1_en   = 1'b1;
                        ent.end1_kind = K_DBL_OP;
                        do_start      = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // character seen between tokens starts the next one
            if (do_start && !f_is_space(i_in_char)) begin
                ent.char_en = 1'b1;
                if (f_is_alpha(i_in_char) || i_in_char == C_UNDER) begin
                    n_mode = M_IDENT;
                end else if (f_is_digit(i_in_char)) begin
                    n_mode = M_NUMBER;
                end else if (i_in_char == C_DQUOTE || i_in_char == C_SQUOTE) begin
                    n_mode = M_STRING;
                    n_open = i_in_char;
                    n_esc  = 1'b0;
                end else if (f_is_dbl(i_in_char)) begin
                    n_mode = M_DBL;
                    n_open = i_in_char;
                end else if (f_is_eq(i_in_char)) begin
                    n_mode = M_OP;
                end else if (f_is_ctrl(i_in_char)) begin
                    ent.end2_en   = 1'b1;
                    ent.end2_kind = K_CTRL;
                    n_mode        = M_IDLE;
                end else begin
                    n_mode = M_PREFIX;
                end
            end
        end
    end

    // push only transactions that cause results
    assign o_push.valid = accept && (ent.end1_en || ent.char_en || ent.end2_en);
    assign o_push.entry = ent;

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_open <= '0;
            r_esc  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_open <= n_open;
            r_esc  <= n_esc;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/stl_queue.sv */
`default_nettype none
module stl_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  stl_pkg::t_qword     i_push,
    output logic                o_full,
    output stl_pkg::t_qword     o_head,
    input  wire logic           i_pop
);
    import stl_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr, r_rptr;
    logic [QAW:0]     r_count;
    logic             do_push, do_pop;

    assign o_full       = r_count == (QAW+1)'(QDEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.entry = r_mem[r_rptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/stl_back.sv */
`default_nettype none
module stl_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  stl_pkg::t_qword     i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_out_char,
    output logic                o_has_char,
    output logic                o_token_end,
    output logic [2:0]          o_token_kind,
    output logic                o_last
);
    import stl_pkg::*;

    logic [2:0] r_done;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_has_char;
    logic       r_token_end;
    logic [2:0] r_kind;
    logic       r_last;
    logic [2:0] rem, pick;
    logic       load, is_last;

    // pick the earliest result slot not yet sent
    always_comb begin
        rem     = {i_head.entry.end2_en, i_head.entry.char_en, i_head.entry.end1_en}
                  & ~r_done;
        pick    = rem & (~rem + 3'd1);
        is_last = (rem & ~pick) == 3'b000;
    end

    assign load  = i_head.valid && (!r_valid || i_ready);
    assign o_pop = load && is_last;

    // slot progress within the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (load) begin
            r_done <= is_last ? 3'b000 : (r_done | pick);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last      <= is_last;
            r_has_char  <= pick[1];
            r_token_end <= !pick[1];
            r_char      <= pick[1] ? i_head.entry.char_val : 8'h00;
            if (pick[0]) begin
                r_kind <= i_head.entry.end1_kind;
            end else if (pick[2]) begin
                r_kind <= i_head.entry.end2_kind;
            end else begin
                r_kind <= K_IDENT;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_char   = r_char;
    assign o_has_char   = r_has_char;
    assign o_token_end  = r_token_end;
    assign o_token_kind = r_kind;
    assign o_last       = r_last;

endmodule
`default_nettype wire

/* rtl/core/script_token_lexer_unit.sv */
// Streaming tokenizer: one source byte per input transaction, results are lexeme
// characters and token-end marks with the token kind, one result per output
// transaction, with o_last on the final result of each input. An input is taken
// every cycle while the four-entry queue between the classifier and the result
// serializer has room; the serializer sends one result per cycle while the output
// is ready, so an input that causes two or three results holds its queue entry
// until the last of them is sent and the sustained input rate follows the output
// result rate (inputs with no result do not enter the queue). The first result is
// registered in the queue and then in the output register before it is offered.
`default_nettype none
module script_token_lexer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_char,
    output logic            o_has_char,
    output logic            o_token_end,
    output logic [2:0]      o_token_kind,
    output logic            o_last
);
    import stl_pkg::*;

    t_qword push, head;
    logic   q_full, pop;

    // classifier and lexer state
    stl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_char     (i_in_char),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    // result groups waiting for the serializer
    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // one result per output transaction
    stl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_has_char   (o_has_char),
        .o_token_end  (o_token_end),
        .o_token_kind (o_token_kind),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

/* rtl/core/stl_checker.sv */
`default_nettype none
`include "script_token_lexer_unit_defines.svh"
module stl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [7:0] i_in_char,
    input wire logic       i_end_of_text,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_out_char,
    input wire logic       o_has_char,
    input wire logic       o_token_end,
    input wire logic [2:0] o_token_kind,
    input wire logic       o_last
);
    import stl_pkg::*;

    // stalled result transaction stays offered
    `STL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    // stalled result payload holds
    `STL_ASSERT_NEXT(a_out_stable, o_valid && !i_ready,
        $stable({o_out_char, o_has_char, o_token_end, o_token_kind, o_last}))
    // each result is either a character or a token end
    `STL_ASSERT_NOW(a_one_kind, o_valid, o_has_char != o_token_end)
    // unused fields are zero and kinds stay in range
    `STL_ASSERT_NOW(a_fields, o_valid, (o_has_char && o_token_kind == K_IDENT)
        || (o_token_end && o_out_char == 8'h00 && o_token_kind <= K_UNCL))

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (.*);
`default_nettype wire
